// File: rtl/core/bptc_pkg.sv
// Shared types and constants for the barometer compensation pipeline.
package bptc_pkg;

    // Pipeline depth from accepted input word to result strobe
    localparam int LATENCY = 9;

    // Register index width and calibration word width
    localparam int REG_INDEX_W = 3;
    localparam int CAL_W       = 16;

    // Temperature thresholds in hundredths of a degree
    localparam logic signed [18:0] TEMP_REF_CENTI = 19'sd2000;
    localparam logic signed [18:0] TEMP_LOW_CENTI = -19'sd1500;

    // Bounds that enclose the reachable span of the first-order temperature
    localparam logic signed [18:0] TEMP_CENTI_MIN = -19'sd129070;
    localparam logic signed [18:0] TEMP_CENTI_MAX = 19'sd133070;

    // Signed 32-bit limits, widened for the saturation compare
    localparam logic signed [44:0] P_MAX = 45'sd2147483647;
    localparam logic signed [44:0] P_MIN = -45'sd2147483648;

    // Calibration register indexes
    typedef enum logic [REG_INDEX_W-1:0] {
        REG_PRESSURE_SENSITIVITY   = 3'd0,
        REG_PRESSURE_OFFSET        = 3'd1,
        REG_SENSITIVITY_TEMP_COEFF = 3'd2,
        REG_OFFSET_TEMP_COEFF      = 3'd3,
        REG_REFERENCE_TEMPERATURE  = 3'd4,
        REG_TEMPERATURE_COEFF      = 3'd5
    } reg_index_t;

    // Input word: one raw conversion pair
    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } sample_t;

    // Result word
    typedef struct packed {
        logic signed [18:0] temperature_centi;
        logic signed [31:0] pressure_pa;
    } result_t;

    // Factory calibration set
    typedef struct packed {
        logic [CAL_W-1:0] pressure_sensitivity;
        logic [CAL_W-1:0] pressure_offset;
        logic [CAL_W-1:0] sensitivity_temp_coeff;
        logic [CAL_W-1:0] offset_temp_coeff;
        logic [CAL_W-1:0] reference_temperature;
        logic [CAL_W-1:0] temperature_coeff;
    } cal_t;

    // Clamp a wide pressure to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [44:0] x);
        logic signed [31:0] r;
        if (x > P_MAX) begin
            r = P_MAX[31:0];
        end
        else if (x < P_MIN) begin
            r = P_MIN[31:0];
        end
        else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/baro_pressure_temp_compensation.sv
// Top level: calibration registers, compensation pipeline and checks.
//
//  channel   direction  handshake                 word
//  --------  ---------  ------------------------  -----------------------------
//  input     in         start high, busy low      sample (raw pressure, raw temp)
//  result    out        done strobe, one cycle    result (temperature, pressure)
//  config    in         cfg_valid and cfg_ready   cfg_index, cfg_data
//
//  A new word is taken every cycle that start is high; busy stays low.
//  Each result passes through the nine register stages of the datapath
//  (products, squares, split D1 * SENS product) after its word is taken.
//  Reset clears the stage valid bits and the six calibration words to zero.
//  The receiver cannot stall, so the pipeline advances on every clock.
module baro_pressure_temp_compensation (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  bptc_pkg::sample_t                  sample,
    output logic                               done,
    output bptc_pkg::result_t                  result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bptc_pkg::REG_INDEX_W-1:0]   cfg_index,
    input  logic [bptc_pkg::CAL_W-1:0]         cfg_data
);

    bptc_pkg::cal_t cal_reg;
    bptc_pkg::cal_t cal_next;
    logic           in_take;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_take   = start && !busy;

    // Decode calibration writes; drop indexes beyond the list
    always_comb
    begin
        cal_next = cal_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bptc_pkg::REG_PRESSURE_SENSITIVITY:   cal_next.pressure_sensitivity   = cfg_data;
                bptc_pkg::REG_PRESSURE_OFFSET:        cal_next.pressure_offset        = cfg_data;
                bptc_pkg::REG_SENSITIVITY_TEMP_COEFF: cal_next.sensitivity_temp_coeff = cfg_data;
                bptc_pkg::REG_OFFSET_TEMP_COEFF:      cal_next.offset_temp_coeff      = cfg_data;
                bptc_pkg::REG_REFERENCE_TEMPERATURE:  cal_next.reference_temperature  = cfg_data;
                bptc_pkg::REG_TEMPERATURE_COEFF:      cal_next.temperature_coeff      = cfg_data;
                default:                              cal_next = cal_reg;
            endcase
        end
    end

    // Hold calibration words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

    // Compensation datapath
    bptc_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_take),
        .sample    (sample),
        .cal       (cal_reg),
        .out_valid (done),
        .result    (result)
    );

    // Every taken word yields a result after the pipeline depth
    a_word_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |-> ##(bptc_pkg::LATENCY) done)
        else $error("taken word produced no result");

    // No result without a word taken one pipeline depth earlier
    a_result_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_take, bptc_pkg::LATENCY))
        else $error("result without a taken word");

    // Temperature stays within its reachable span
    a_temp_span: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.temperature_centi >= bptc_pkg::TEMP_CENTI_MIN)
              && (result.temperature_centi <= bptc_pkg::TEMP_CENTI_MAX))
        else $error("temperature outside reachable span");

endmodule

// File: rtl/core/bptc_pipe.sv
// Nine-stage compensation datapath: temperature, offset, sensitivity, pressure.
module bptc_pipe (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  bptc_pkg::sample_t sample,
    input  bptc_pkg::cal_t    cal,
    output logic              out_valid,
    output bptc_pkg::result_t result
);

    // Valid bits, one per stage
    logic [bptc_pkg::LATENCY-1:0] valid_reg;
    logic [bptc_pkg::LATENCY-1:0] valid_next;

    // Stage 1: temperature difference
    logic        [23:0] s1_d1_reg;
    logic signed [24:0] s1_dt_reg;
    logic signed [24:0] s1_dt_next;

    // Stage 2: first-order products
    logic        [23:0] s2_d1_reg;
    logic signed [41:0] s2_off_prod_reg, s2_off_prod_next;
    logic signed [41:0] s2_sens_prod_reg, s2_sens_prod_next;
    logic signed [41:0] s2_temp_prod_reg, s2_temp_prod_next;

    // Stage 3: first-order offset, sensitivity, temperature
    logic        [23:0] s3_d1_reg;
    logic signed [39:0] s3_off_reg, s3_off_next;
    logic signed [39:0] s3_sens_reg, s3_sens_next;
    logic signed [18:0] s3_temp_reg, s3_temp_next;
    logic signed [41:0] off_shift, sens_shift, temp_shift;

    // Stage 4: squares and threshold flags
    logic        [23:0] s4_d1_reg;
    logic signed [39:0] s4_off_reg, s4_sens_reg;
    logic signed [18:0] s4_temp_reg;
    logic        [34:0] s4_sq_reg, s4_sq_next;
    logic        [34:0] s4_sq2_reg, s4_sq2_next;
    logic               s4_lt_ref_reg, s4_lt_low_reg;
    logic signed [18:0] d_diff, e_diff;
    logic signed [37:0] d_sq, e_sq;

    // Stage 5: second-order terms
    logic        [23:0] s5_d1_reg;
    logic signed [39:0] s5_off_reg, s5_sens_reg;
    logic signed [18:0] s5_temp_reg;
    logic        [37:0] s5_t5_reg, s5_t5_next;
    logic        [37:0] s5_t7_reg, s5_t7_next;
    logic        [38:0] s5_t11_reg, s5_t11_next;

    // Stage 6: corrected offset and sensitivity
    logic        [23:0] s6_d1_reg;
    logic signed [18:0] s6_temp_reg;
    logic signed [39:0] s6_off_reg, s6_off_next;
    logic signed [39:0] s6_sens_reg, s6_sens_next;

    // Stage 7: partial products of D1 and sensitivity
    logic signed [18:0] s7_temp_reg;
    logic signed [39:0] s7_off_reg;
    logic        [43:0] s7_lo_reg, s7_lo_next;
    logic signed [44:0] s7_hi_reg, s7_hi_next;

    // Stage 8: full product
    logic signed [18:0] s8_temp_reg;
    logic signed [39:0] s8_off_reg;
    logic signed [64:0] s8_prod_reg, s8_prod_next;

    // Stage 9: pressure and output register
    logic signed [44:0] p_diff;
    logic signed [44:0] p_wide;
    bptc_pkg::result_t  result_reg, result_next;

    // Advance valid bits
    assign valid_next = {valid_reg[bptc_pkg::LATENCY-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage logic
    always_comb
    begin
        // dT = D2 - C5 * 2^8
        s1_dt_next = $signed({1'b0, sample.raw_temperature})
                   - $signed({1'b0, cal.reference_temperature, 8'h00});

        // Products of dT with C4, C3, C6
        s2_off_prod_next  = s1_dt_reg * $signed({1'b0, cal.offset_temp_coeff});
        s2_sens_prod_next = s1_dt_reg * $signed({1'b0, cal.sensitivity_temp_coeff});
        s2_temp_prod_next = s1_dt_reg * $signed({1'b0, cal.temperature_coeff});

        // Scale products and add calibration bases
        off_shift    = s2_off_prod_reg >>> 7;
        sens_shift   = s2_sens_prod_reg >>> 8;
        temp_shift   = s2_temp_prod_reg >>> 23;
        s3_off_next  = $signed({8'h00, cal.pressure_offset, 16'h0000}) + off_shift[39:0];
        s3_sens_next = $signed({9'd0, cal.pressure_sensitivity, 15'd0})
                     + sens_shift[39:0];
        s3_temp_next = bptc_pkg::TEMP_REF_CENTI + temp_shift[18:0];

        // Distances from both thresholds and their squares
        d_diff      = s3_temp_reg - bptc_pkg::TEMP_REF_CENTI;
        e_diff      = s3_temp_reg - bptc_pkg::TEMP_LOW_CENTI;
        d_sq        = d_diff * d_diff;
        e_sq        = e_diff * e_diff;
        s4_sq_next  = d_sq[34:0];
        s4_sq2_next = e_sq[34:0];

        // Multiples 5, 7, 11 of the squares, dropped at or above the thresholds
        s5_t5_next  = '0;
        s5_t7_next  = '0;
        s5_t11_next = '0;
        if (s4_lt_ref_reg)
        begin
            s5_t5_next = {1'b0, s4_sq_reg, 2'b00} + {3'b000, s4_sq_reg};
            if (s4_lt_low_reg)
            begin
                s5_t7_next  = {s4_sq2_reg, 3'b000} - {3'b000, s4_sq2_reg};
                s5_t11_next = {1'b0, s4_sq2_reg, 3'b000} + {3'b000, s4_sq2_reg, 1'b0}
                            + {4'h0, s4_sq2_reg};
            end
        end

        // Subtract second-order terms
        s6_off_next  = s5_off_reg - $signed({3'b000, s5_t5_reg[37:1]})
                     - $signed({2'b00, s5_t7_reg});
        s6_sens_next = s5_sens_reg - $signed({4'h0, s5_t5_reg[37:2]})
                     - $signed({2'b00, s5_t11_reg[38:1]});

        // Split sensitivity into a low unsigned and a high signed half
        s7_lo_next = s6_d1_reg * s6_sens_reg[19:0];
        s7_hi_next = $signed({1'b0, s6_d1_reg}) * $signed(s6_sens_reg[39:20]);

        // Recombine the partial products
        s8_prod_next = {s7_hi_reg, 20'h00000} + {21'd0, s7_lo_reg};

        // P = (D1 * SENS / 2^21 - OFF) / 2^15, clamped
        p_diff = $signed(s8_prod_reg[64:21]) - s8_off_reg;
        p_wide = p_diff >>> 15;
        result_next.temperature_centi = s8_temp_reg;
        result_next.pressure_pa       = bptc_pkg::sat32(p_wide);
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_d1_reg        <= sample.raw_pressure;
        s1_dt_reg        <= s1_dt_next;

        s2_d1_reg        <= s1_d1_reg;
        s2_off_prod_reg  <= s2_off_prod_next;
        s2_sens_prod_reg <= s2_sens_prod_next;
        s2_temp_prod_reg <= s2_temp_prod_next;

        s3_d1_reg        <= s2_d1_reg;
        s3_off_reg       <= s3_off_next;
        s3_sens_reg      <= s3_sens_next;
        s3_temp_reg      <= s3_temp_next;

        s4_d1_reg        <= s3_d1_reg;
        s4_off_reg       <= s3_off_reg;
        s4_sens_reg      <= s3_sens_reg;
        s4_temp_reg      <= s3_temp_reg;
        s4_sq_reg        <= s4_sq_next;
        s4_sq2_reg       <= s4_sq2_next;
        s4_lt_ref_reg    <= d_diff[18];
        s4_lt_low_reg    <= e_diff[18];

        s5_d1_reg        <= s4_d1_reg;
        s5_off_reg       <= s4_off_reg;
        s5_sens_reg      <= s4_sens_reg;
        s5_temp_reg      <= s4_temp_reg;
        s5_t5_reg        <= s5_t5_next;
        s5_t7_reg        <= s5_t7_next;
        s5_t11_reg       <= s5_t11_next;

        s6_d1_reg        <= s5_d1_reg;
        s6_temp_reg      <= s5_temp_reg;
        s6_off_reg       <= s6_off_next;
        s6_sens_reg      <= s6_sens_next;

        s7_temp_reg      <= s6_temp_reg;
        s7_off_reg       <= s6_off_reg;
        s7_lo_reg        <= s7_lo_next;
        s7_hi_reg        <= s7_hi_next;

        s8_temp_reg      <= s7_temp_reg;
        s8_off_reg       <= s7_off_reg;
        s8_prod_reg      <= s8_prod_next;

        result_reg       <= result_next;
    end

    assign out_valid = valid_reg[bptc_pkg::LATENCY-1];
    assign result    = result_reg;

endmodule

// File: tb/tb_baro_pressure_temp_compensation.sv
// Self-checking testbench for the barometer pressure and temperature compensation block.
module tb_baro_pressure_temp_compensation;
    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes beyond the calibration set; writes there must be dropped
    localparam logic [bptc_pkg::REG_INDEX_W-1:0] SPARE_INDEX_LO = 3'd6;
    localparam logic [bptc_pkg::REG_INDEX_W-1:0] SPARE_INDEX_HI = 3'd7;
    localparam int MAX_REPORTS = 10;
    localparam int IDLE_PERCENT = 27;

    logic                             clk;
    logic                             rst_n;
    logic                             start;
    logic                             busy;
    bptc_pkg::sample_t                sample;
    logic                             done;
    bptc_pkg::result_t                result;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [bptc_pkg::REG_INDEX_W-1:0] cfg_index;
    logic [bptc_pkg::CAL_W-1:0]       cfg_data;

    bptc_pkg::cal_t    cal_copy;
    bptc_pkg::result_t pending_readings[$];
    int                failures;
    bit                idle_en;

    baro_pressure_temp_compensation DUT (.*);

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Count a failure, report only the first few
    function automatic void note_failure(string msg);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    // Work out temperature and pressure from one raw pair and the held calibration
    function automatic bptc_pkg::result_t compensate_sample(bptc_pkg::sample_t s);
        longint            d1, d2, c1, c2, c3, c4, c5, c6;
        longint            dt, off, sens, temp, off2, sens2, dev, sq, p;
        longint            ref_c, low_c;
        bptc_pkg::result_t r;
        d1 = {40'd0, s.raw_pressure};
        d2 = {40'd0, s.raw_temperature};
        c1 = {48'd0, cal_copy.pressure_sensitivity};
        c2 = {48'd0, cal_copy.pressure_offset};
        c3 = {48'd0, cal_copy.sensitivity_temp_coeff};
        c4 = {48'd0, cal_copy.offset_temp_coeff};
        c5 = {48'd0, cal_copy.reference_temperature};
        c6 = {48'd0, cal_copy.temperature_coeff};
        ref_c = longint'(bptc_pkg::TEMP_REF_CENTI);
        low_c = longint'(bptc_pkg::TEMP_LOW_CENTI);

        dt   = d2 - c5 * 256;
        off  = c2 * 65536 + ((dt * c4) >>> 7);
        sens = c1 * 32768 + ((dt * c3) >>> 8);
        temp = ref_c + ((dt * c6) >>> 23);

        // Second-order terms when cold, more when very cold
        off2  = 0;
        sens2 = 0;
        if (temp < ref_c)
        begin
            dev   = temp - ref_c;
            sq    = dev * dev;
            off2  = (5 * sq) >>> 1;
            sens2 = (5 * sq) >>> 2;
            if (temp < low_c)
            begin
                dev   = temp - low_c;
                sq    = dev * dev;
                off2  = off2 + 7 * sq;
                sens2 = sens2 + ((11 * sq) >>> 1);
            end
        end
        off  = off - off2;
        sens = sens - sens2;

        p = (((d1 * sens) >>> 21) - off) >>> 15;
        if (p > 64'sd2147483647)
            p = 64'sd2147483647;
        else if (p < -64'sd2147483648)
            p = -64'sd2147483648;

        r.temperature_centi = temp[18:0];
        r.pressure_pa       = p[31:0];
        return r;
    endfunction

    // Offer one word, hold it until taken and log its expected reading; returns at a falling edge
    task automatic send_pair(input logic [23:0] d1, input logic [23:0] d2);
        bptc_pkg::sample_t s;
        s.raw_pressure    = d1;
        s.raw_temperature = d2;
        if (idle_en)
        begin
            while ($urandom_range(0, 99) < IDLE_PERCENT)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        start  <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (busy);
        pending_readings.push_back(compensate_sample(s));
        @(negedge clk);
    endtask

    // Drop start and wait until every reading is back and the pipe is empty
    task automatic settle();
        start <= 1'b0;
        @(negedge clk);
        while (pending_readings.size() != 0)
            @(negedge clk);
        repeat (bptc_pkg::LATENCY + 2) @(negedge clk);
    endtask

    // Write one register; leaves valid high for a following write
    task automatic write_reg(input logic [bptc_pkg::REG_INDEX_W-1:0] idx,
                             input logic [bptc_pkg::CAL_W-1:0]       data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            bptc_pkg::REG_PRESSURE_SENSITIVITY:
                cal_copy.pressure_sensitivity   = data;
            bptc_pkg::REG_PRESSURE_OFFSET:
                cal_copy.pressure_offset        = data;
            bptc_pkg::REG_SENSITIVITY_TEMP_COEFF:
                cal_copy.sensitivity_temp_coeff = data;
            bptc_pkg::REG_OFFSET_TEMP_COEFF:
                cal_copy.offset_temp_coeff      = data;
            bptc_pkg::REG_REFERENCE_TEMPERATURE:
                cal_copy.reference_temperature  = data;
            bptc_pkg::REG_TEMPERATURE_COEFF:
                cal_copy.temperature_coeff      = data;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Idle the block, then load a full calibration set; valid is driven low before return
    task automatic load_calibration(input bptc_pkg::cal_t c);
        settle();
        write_reg(bptc_pkg::REG_PRESSURE_SENSITIVITY,   c.pressure_sensitivity);
        write_reg(bptc_pkg::REG_PRESSURE_OFFSET,        c.pressure_offset);
        write_reg(bptc_pkg::REG_SENSITIVITY_TEMP_COEFF, c.sensitivity_temp_coeff);
        write_reg(bptc_pkg::REG_OFFSET_TEMP_COEFF,      c.offset_temp_coeff);
        write_reg(bptc_pkg::REG_REFERENCE_TEMPERATURE,  c.reference_temperature);
        write_reg(bptc_pkg::REG_TEMPERATURE_COEFF,      c.temperature_coeff);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Registers clear to zero on reset; run extremes against the cleared set
    task automatic test_reset_calibration();
        send_pair(24'h000000, 24'h000000);
        send_pair(24'hFFFFFF, 24'hFFFFFF);
        send_pair(24'hFFFFFF, 24'h000000);
        send_pair(24'h000000, 24'hFFFFFF);
    endtask

    // Typical factory set and a textbook conversion pair
    task automatic test_typical_reading();
        load_calibration('{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312});
        send_pair(24'd9085466, 24'd8569150);
        send_pair(24'hAAAAAA, 24'h555555);
        send_pair(24'h555555, 24'hAAAAAA);
    endtask

    // Put the temperature right on either side of both cold thresholds
    task automatic test_cold_thresholds();
        // Reference word 0x8000 and coefficient 0x8000 give TEMP = 2000 + dT/256
        load_calibration('{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'h8000, 16'h8000});
        send_pair(24'd9085466, 24'd8388608);
        send_pair(24'd9085466, 24'd8388607);
        send_pair(24'd9085466, 24'd7492608);
        send_pair(24'd9085466, 24'd7492607);
        send_pair(24'd9085466, 24'd0);
    endtask

    // All calibration words at full scale: hottest and coldest reachable temperature
    task automatic test_full_scale();
        load_calibration({6{16'hFFFF}});
        send_pair(24'hFFFFFF, 24'h000000);
        send_pair(24'h000000, 24'h000000);
        send_pair(24'hFFFFFF, 24'hFFFFFF);
        settle();
        write_reg(bptc_pkg::REG_REFERENCE_TEMPERATURE, 16'h0000);
        cfg_valid <= 1'b0;
        send_pair(24'hFFFFFF, 24'hFFFFFF);
        send_pair(24'h000000, 24'hFFFFFF);
    endtask

    // Writes to indexes past the last register must leave the set untouched
    task automatic test_spare_index();
        load_calibration('{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312});
        write_reg(SPARE_INDEX_LO, 16'hFFFF);
        write_reg(SPARE_INDEX_HI, 16'h0000);
        cfg_valid <= 1'b0;
        send_pair(24'd9085466, 24'd8569150);
        send_pair(24'd9085466, 24'd8000000);
    endtask

    // Random calibration sets and random pairs, with idle gaps on and off
    task automatic test_random_readings();
        bptc_pkg::cal_t                   c;
        logic [15:0]                      w[6];
        int                               d2;
        logic [bptc_pkg::REG_INDEX_W-1:0] spare;
        for (int ph = 0; ph < 8; ph++)
        begin
            // Mostly random words, with zero and full scale mixed in
            foreach (w[i])
            begin
                case ($urandom_range(0, 7))
                    0:       w[i] = 16'h0000;
                    1:       w[i] = 16'hFFFF;
                    default: w[i] = 16'($urandom_range(0, 16'hFFFF));
                endcase
            end
            c = {w[0], w[1], w[2], w[3], w[4], w[5]};
            load_calibration(c);
            if ($urandom_range(0, 3) == 0)
            begin
                spare = ($urandom_range(0, 1) == 0) ? SPARE_INDEX_LO : SPARE_INDEX_HI;
                write_reg(spare, 16'($urandom_range(0, 16'hFFFF)));
                cfg_valid <= 1'b0;
            end
            // Hold one phase gap-free for back-to-back traffic
            idle_en = (ph != 2);
            repeat (50)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    // Temperature word close to the reference, both sides
                    d2 = int'(cal_copy.reference_temperature) * 256
                         + $urandom_range(0, 1 << 21) - (1 << 20);
                    send_pair(24'($urandom_range(0, 24'hFFFFFF)), d2[23:0]);
                end
                else
                begin
                    send_pair(24'($urandom_range(0, 24'hFFFFFF)),
                              24'($urandom_range(0, 24'hFFFFFF)));
                end
            end
        end
        idle_en = 1'b1;
    endtask

    // Compare each result word with the oldest expected reading
    always @(posedge clk)
    begin : check_readings
        bptc_pkg::result_t want;
        if (rst_n && done)
        begin
            if (pending_readings.size() == 0)
            begin
                note_failure($sformatf("unexpected result temp=%0d pressure=%0d",
                                       result.temperature_centi, result.pressure_pa));
            end
            else
            begin
                want = pending_readings.pop_front();
                if (result.temperature_centi !== want.temperature_centi)
                    note_failure($sformatf("temperature_centi expected %0d got %0d",
                                           want.temperature_centi, result.temperature_centi));
                if (result.pressure_pa !== want.pressure_pa)
                    note_failure($sformatf("pressure_pa expected %0d got %0d",
                                           want.pressure_pa, result.pressure_pa));
            end
        end
    end

    // Reset, run the tests in turn, then drain and report
    initial
    begin
        failures  = 0;
        idle_en   = 1'b1;
        cal_copy  = '0;
        rst_n     = 1'b0;
        start     = 1'b0;
        sample    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_calibration();
        test_typical_reading();
        test_cold_thresholds();
        test_full_scale();
        test_spare_index();
        test_random_readings();

        settle();
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/bptc_pkg.sv
rtl/core/bptc_pipe.sv
rtl/core/baro_pressure_temp_compensation.sv
tb/tb_baro_pressure_temp_compensation.sv
